// ===== design/sdcrc_pkg.sv =====
// Package for the SD data-block CRC appender: queue entry type, sizes and the
// CRC16-CCITT update functions. No dependencies.
`timescale 1ns / 1ps

package sdcrc_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [3:0] IdxData       = 4'd0;
  localparam logic [3:0] IdxLastSerial = 4'd2;
  localparam logic [3:0] IdxLastLines  = 4'd8;

  localparam logic [2:0] CfgAddrMode = 3'd0;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             four_bit;
    logic [15:0]      serial;
    logic [3:0][15:0] lines;
  } sdcrc_entry_t;

  function automatic logic [15:0] crc_bit(input logic [15:0] crc, input logic din);
    logic [15:0] c;
    begin
      c = crc ^ {din, 15'd0};
      crc_bit = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    begin
      c = crc;
      for (int b = 7; b >= 0; b--) begin
        c = crc_bit(c, d[b]);
      end
      crc_byte = c;
    end
  endfunction

endpackage

// ===== design/sd_data_block_crc16.sv =====
// Top level of the SD data-block CRC16 appender: configuration register,
// front end, queue and back end. Depends on sdcrc_pkg and the sdcrc_* modules.
//
//   channel | direction | handshake          | contents
//   input   | in        | in_valid/in_stall  | data_byte, last_byte
//   output  | out       | out_valid/out_stall| out_byte, is_crc, block_end
//   config  | in        | APB psel/penable   | four_bit_mode at byte address 0
//
// A byte is taken every cycle while the queue has room; its transfer out
// passes through a queue slot and then the output register.
// A last byte expands to 3 output transfers (single line) or 9 (four lines);
// unless stalled, the output register sends one transfer per cycle (sustained rate).
// Reset is synchronous and clears the CRCs, the queue, the output and the mode.
// Output stall backs up into the queue; input stall rises only when it is full.
`timescale 1ns / 1ps

module sd_data_block_crc16
  import sdcrc_pkg::*;
#(
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_crc,
  output logic        block_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic         four_bit_mode;
  logic         q_full;
  logic         q_not_empty;
  logic         push;
  logic         pop;
  sdcrc_entry_t push_entry;
  sdcrc_entry_t head;

  assign pready = 1'b1;
  assign prdata = (paddr == CfgAddrMode) ? {31'd0, four_bit_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr == CfgAddrMode)) begin
      four_bit_mode <= pwdata[0];
    end
  end

  sdcrc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .four_bit_mode (four_bit_mode),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .push          (push),
    .entry         (push_entry)
  );

  sdcrc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  sdcrc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .is_crc      (is_crc),
    .block_end   (block_end)
  );

endmodule

// ===== design/sdcrc_front.sv =====
// Front end of the SD CRC appender: accepts block bytes and folds them into
// the serial and per-line CRCs. Depends on sdcrc_pkg.
`timescale 1ns / 1ps

module sdcrc_front
  import sdcrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  input  logic         four_bit_mode,
  input  logic         q_full,
  output logic         in_stall,
  output logic         push,
  output sdcrc_entry_t entry
);

  logic [15:0]      serial_crc;
  logic [15:0]      serial_crc_next;
  logic [3:0][15:0] line_crc;
  logic [3:0][15:0] line_crc_next;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    serial_crc_next = crc_byte(serial_crc, data_byte);
    for (int n = 0; n < 4; n++) begin
      line_crc_next[n] = crc_bit(crc_bit(line_crc[n], data_byte[n + 4]), data_byte[n]);
    end
    entry.data     = data_byte;
    entry.last     = last_byte;
    entry.four_bit = four_bit_mode;
    entry.serial   = serial_crc_next;
    entry.lines    = line_crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      serial_crc <= '0;
      line_crc   <= '0;
    end else if (push) begin
      if (last_byte) begin
        serial_crc <= '0;
        line_crc   <= '0;
      end else begin
        serial_crc <= serial_crc_next;
        line_crc   <= line_crc_next;
      end
    end
  end

endmodule

// ===== design/sdcrc_queue.sv =====
// Short queue of classified bytes between the front and back ends of the
// SD CRC appender. Depends on sdcrc_pkg.
`timescale 1ns / 1ps

module sdcrc_queue
  import sdcrc_pkg::*;
#(
  parameter int Depth = QueueDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  sdcrc_entry_t push_entry,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output sdcrc_entry_t head
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCount = CW'(Depth);

  sdcrc_entry_t slots [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FullCount);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/sdcrc_back.sv =====
// Back end of the SD CRC appender: sends each queued byte and, after the
// last byte of a block, its CRC bytes through an output register. Depends on sdcrc_pkg.
`timescale 1ns / 1ps

module sdcrc_back
  import sdcrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_not_empty,
  input  sdcrc_entry_t head,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_byte,
  output logic         is_crc,
  output logic         block_end
);

  logic [3:0] idx;
  logic [3:0] idx_final;
  logic       advance;
  logic       final_byte;
  logic [2:0] k;
  logic [3:0] pos_hi;
  logic [3:0] pos_lo;
  logic [7:0] crc_byte_sel;

  assign advance    = !out_valid || !out_stall;
  assign idx_final  = !head.last ? IdxData : (head.four_bit ? IdxLastLines : IdxLastSerial);
  assign final_byte = (idx == idx_final);
  assign pop        = advance && q_not_empty && final_byte;

  always_comb begin
    k      = 3'(idx - 4'd1);
    pos_hi = 4'd15 - {k, 1'b0};
    pos_lo = pos_hi - 4'd1;
    if (head.four_bit) begin
      for (int n = 0; n < 4; n++) begin
        crc_byte_sel[n + 4] = head.lines[n][pos_hi];
        crc_byte_sel[n]     = head.lines[n][pos_lo];
      end
    end else begin
      crc_byte_sel = (idx == IdxLastSerial) ? head.serial[7:0] : head.serial[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= IdxData;
    end else if (advance) begin
      out_valid <= q_not_empty;
      if (q_not_empty) begin
        idx <= final_byte ? IdxData : idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_not_empty) begin
      out_byte  <= (idx == IdxData) ? head.data : crc_byte_sel;
      is_crc    <= (idx != IdxData);
      block_end <= (idx != IdxData) && final_byte;
    end
  end

endmodule
